[design/md4_message_digest_unit_macros.svh]
// assertion macros for the md4 message digest unit
// depends on nothing; each macro expects clk_i and rst_ni in scope
`ifndef MD4_MESSAGE_DIGEST_UNIT_MACROS_SVH
`define MD4_MESSAGE_DIGEST_UNIT_MACROS_SVH

// property checked at every clock edge outside reset
`define MD4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle, outside reset
`define MD4_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

[design/md4_pkg.sv]
// md4 package: sequencer states, initial chaining words, round constants
// and the per-round message index, rotate amount and boolean functions
package md4_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } md4_state_e;

  localparam logic [31:0] INIT_A   = 32'h67452301;
  localparam logic [31:0] INIT_B   = 32'hefcdab89;
  localparam logic [31:0] INIT_C   = 32'h98badcfe;
  localparam logic [31:0] INIT_D   = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5A827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;
  localparam logic [31:0] PAD_BYTE = 32'h00000080;

  localparam logic [5:0] LAST_ROUND = 6'd47;
  localparam logic [3:0] LAST_SLOT  = 4'd15;
  localparam logic [3:0] LEN_SLOT   = 4'd14;
  localparam logic [2:0] FULL_WORD  = 3'd4;

  // message word used by a round: straight, then with its bit pairs swapped, then bit-reversed
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] j;
    j = rnd[3:0];
    case (rnd[5:4])
      2'd0:    msg_index = j;
      2'd1:    msg_index = {j[1:0], j[3:2]};
      default: msg_index = {j[0], j[1], j[2], j[3]};
    endcase
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
    case (rnd[5:4])
      2'd0: begin
        case (rnd[1:0])
          2'd0:    rot_amt = 5'd3;
          2'd1:    rot_amt = 5'd7;
          2'd2:    rot_amt = 5'd11;
          default: rot_amt = 5'd19;
        endcase
      end
      2'd1: begin
        case (rnd[1:0])
          2'd0:    rot_amt = 5'd3;
          2'd1:    rot_amt = 5'd5;
          2'd2:    rot_amt = 5'd9;
          default: rot_amt = 5'd13;
        endcase
      end
      default: begin
        case (rnd[1:0])
          2'd0:    rot_amt = 5'd3;
          2'd1:    rot_amt = 5'd9;
          2'd2:    rot_amt = 5'd11;
          default: rot_amt = 5'd15;
        endcase
      end
    endcase
  endfunction

  // boolean function of the round with its additive constant folded in
  function automatic logic [31:0] round_f(input logic [1:0] rsel, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    case (rsel)
      2'd0:    round_f = (b & c) | (~b & d);
      2'd1:    round_f = ((b & c) | (b & d) | (c & d)) + K_ROUND2;
      default: round_f = (b ^ c ^ d) + K_ROUND3;
    endcase
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {v, v} << s;
    rotl32 = dbl[63:32];
  endfunction

endpackage

[design/md4_message_digest_unit.sv]
// md4 message digest unit: word-streaming md4 hash with padding and length
// depends on md4_pkg and md4_message_digest_unit_macros.svh
//
// usage
// - input stream: one 32-bit message word per transfer, first byte in bits 7..0,
//   with a valid byte count (0..4) and tlast on the final word of a message;
//   short or empty words are honored only together with tlast
// - output stream: one transfer per message, the 128-bit digest as words a..d
// - a word is taken while the unit is idle; every 16th word starts a compression
//   (load state, 48 rounds, fold state) through the single round unit, during
//   which tready is low
// - the 48 serial rounds of the shared round adder and rotator set the block cost
// - after tlast the unit writes the pad byte (unless the last word carried it),
//   zero fill and the 64-bit bit length one word per cycle into the block buffer,
//   runs one or two more compressions, then presents the digest once the output
//   register is free
// - the digest sits in an output register; the unit keeps taking words of the
//   next message while it waits, and only stalls at the end of that next
//   message until the previous digest has been taken
// - reset returns the chaining words to the md4 initial values and clears the
//   word count and length; the block buffer is not cleared (always filled
//   from slot 0 before it is read)
`include "md4_message_digest_unit_macros.svh"

module md4_message_digest_unit
  import md4_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [31:0] data_word, [34:32] valid_bytes, [39:35] zero
  input  logic [39:0]  s_axis_tdata_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] digest_a, [63:32] digest_b, [95:64] digest_c, [127:96] digest_d
  output logic [127:0] m_axis_tdata_o
);

  // sequencer and control state
  md4_state_e  state_q, state_d;
  logic [5:0]  rnd_q, rnd_d;          // round counter of the compression
  logic [3:0]  cnt_q, cnt_d;          // words held in the current block
  logic [63:0] len_q, len_d;          // message length in bits
  logic        pad_q, pad_d;          // message end seen, padding in progress
  logic        need80_q, need80_d;    // pad byte still owed as a word of its own
  logic        lenlo_q, lenlo_d;      // low length word already written
  logic        final_q, final_d;      // last block of the message is written
  logic        out_valid_q, out_valid_d;

  // chaining words and working words of the round unit
  logic [31:0] ch_a_q, ch_b_q, ch_c_q, ch_d_q;
  logic [31:0] ch_a_d, ch_b_d, ch_c_d, ch_d_d;
  logic [31:0] w_a_q, w_b_q, w_c_q, w_d_q;
  logic [31:0] w_a_d, w_b_d, w_c_d, w_d_d;
  logic [127:0] dig_q, dig_d;

  // block buffer, one write and one registered read per cycle
  logic [31:0] blk_mem [16];
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_raddr;
  logic [31:0] x_q;

  // input side decode
  logic        in_xfer;
  logic [31:0] in_word;
  logic [2:0]  in_vb;
  logic [2:0]  vb_eff;
  logic [31:0] byte_mask;
  logic [31:0] last_word;

  // round unit
  logic [31:0] rnd_sum;
  logic [31:0] rnd_t;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_word         = s_axis_tdata_i[31:0];
  assign in_vb           = s_axis_tdata_i[34:32];

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = dig_q;

  // words without tlast, and counts above four, are full words
  assign vb_eff = (!s_axis_tlast_i || (in_vb > FULL_WORD)) ? FULL_WORD : in_vb;

  always_comb begin
    case (vb_eff)
      3'd0:    byte_mask = 32'h00000000;
      3'd1:    byte_mask = 32'h000000ff;
      3'd2:    byte_mask = 32'h0000ffff;
      3'd3:    byte_mask = 32'h00ffffff;
      default: byte_mask = 32'hffffffff;
    endcase
  end

  // short final word carries the pad byte right after its valid bytes
  assign last_word = (vb_eff == FULL_WORD) ? in_word :
                     ((in_word & byte_mask) | (PAD_BYTE << {vb_eff[1:0], 3'b000}));

  // one md4 step: add, rotate
  assign rnd_sum = w_a_q + round_f(rnd_q[5:4], w_b_q, w_c_q, w_d_q) + x_q;
  assign rnd_t   = rotl32(rnd_sum, rot_amt(rnd_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cnt_q == LAST_SLOT) begin
            state_d = ST_LOAD;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (cnt_q == LAST_SLOT) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_ROUND;
      ST_ROUND: begin
        if (rnd_q == LAST_ROUND) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (final_q) begin
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and buffer control
  always_comb begin
    rnd_d       = rnd_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    pad_d       = pad_q;
    need80_d    = need80_q;
    lenlo_d     = lenlo_q;
    final_d     = final_q;
    out_valid_d = out_valid_q;
    ch_a_d      = ch_a_q;
    ch_b_d      = ch_b_q;
    ch_c_d      = ch_c_q;
    ch_d_d      = ch_d_q;
    w_a_d       = w_a_q;
    w_b_d       = w_b_q;
    w_c_d       = w_c_q;
    w_d_d       = w_d_q;
    dig_d       = dig_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q;
    mem_wdata   = 32'h0;
    mem_raddr   = msg_index(rnd_q + 6'd1);

    // digest transfer done
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          mem_we    = 1'b1;
          mem_wdata = s_axis_tlast_i ? last_word : in_word;
          cnt_d     = cnt_q + 4'd1;
          len_d     = len_q + {58'd0, vb_eff, 3'b000};
          if (s_axis_tlast_i) begin
            pad_d    = 1'b1;
            need80_d = (vb_eff == FULL_WORD);
          end
        end
      end
      ST_PAD: begin
        // pad byte, then zeros, with the length in the last two slots
        mem_we = 1'b1;
        cnt_d  = cnt_q + 4'd1;
        if (need80_q) begin
          mem_wdata = PAD_BYTE;
          need80_d  = 1'b0;
        end else if ((cnt_q == LEN_SLOT) && !lenlo_q) begin
          mem_wdata = len_q[31:0];
          lenlo_d   = 1'b1;
        end else if ((cnt_q == LAST_SLOT) && lenlo_q) begin
          mem_wdata = len_q[63:32];
          final_d   = 1'b1;
        end else begin
          mem_wdata = 32'h0;
        end
      end
      ST_LOAD: begin
        w_a_d     = ch_a_q;
        w_b_d     = ch_b_q;
        w_c_d     = ch_c_q;
        w_d_d     = ch_d_q;
        rnd_d     = 6'd0;
        mem_raddr = msg_index(6'd0);
      end
      ST_ROUND: begin
        w_a_d = w_d_q;
        w_d_d = w_c_q;
        w_c_d = w_b_q;
        w_b_d = rnd_t;
        rnd_d = rnd_q + 6'd1;
      end
      ST_FOLD: begin
        ch_a_d = ch_a_q + w_a_q;
        ch_b_d = ch_b_q + w_b_q;
        ch_c_d = ch_c_q + w_c_q;
        ch_d_d = ch_d_q + w_d_q;
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          dig_d       = {ch_d_q, ch_c_q, ch_b_q, ch_a_q};
          out_valid_d = 1'b1;
          ch_a_d      = INIT_A;
          ch_b_d      = INIT_B;
          ch_c_d      = INIT_C;
          ch_d_d      = INIT_D;
          cnt_d       = 4'd0;
          len_d       = 64'd0;
          pad_d       = 1'b0;
          need80_d    = 1'b0;
          lenlo_d     = 1'b0;
          final_d     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= 6'd0;
      cnt_q       <= 4'd0;
      len_q       <= 64'd0;
      pad_q       <= 1'b0;
      need80_q    <= 1'b0;
      lenlo_q     <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ch_a_q      <= INIT_A;
      ch_b_q      <= INIT_B;
      ch_c_q      <= INIT_C;
      ch_d_q      <= INIT_D;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      pad_q       <= pad_d;
      need80_q    <= need80_d;
      lenlo_q     <= lenlo_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
      ch_a_q      <= ch_a_d;
      ch_b_q      <= ch_b_d;
      ch_c_q      <= ch_c_d;
      ch_d_q      <= ch_d_d;
    end
  end

  // working words and digest register need no reset
  always_ff @(posedge clk_i) begin
    w_a_q <= w_a_d;
    w_b_q <= w_b_d;
    w_c_q <= w_c_d;
    w_d_q <= w_d_d;
    dig_q <= dig_d;
  end

  // block buffer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      blk_mem[mem_waddr] <= mem_wdata;
    end
    x_q <= blk_mem[mem_raddr];
  end

  // a compression always starts on a freshly filled block
  `MD4_ASSERT(a_load_full_block, (state_q != ST_LOAD) || (cnt_q == 4'd0), "load not on full block")
  // the round counter never runs past the last step
  `MD4_ASSERT(a_round_range, (state_q != ST_ROUND) || (rnd_q <= LAST_ROUND), "round out of range")
  // the length trailer is only written once the message end was seen
  `MD4_ASSERT(a_final_in_pad, !final_q || (pad_q && lenlo_q), "final block without padding")
  // a plain block returns straight to taking words
  `MD4_ASSERT_NEXT(a_fold_idle, (state_q == ST_FOLD) && !pad_q, state_q == ST_IDLE, "no idle")
  // in the output state, a free output register is loaded with the digest
  `MD4_ASSERT_NEXT(a_digest_src, (state_q == ST_OUT) && !out_valid_q, out_valid_q, "no digest")

endmodule

[sim/tb_md4_message_digest_unit.sv]
// testbench for md4_message_digest_unit: streams messages, predicts digests
// depends on md4_pkg and the design files, nothing else
`timescale 1ns / 100ps

module tb_md4_message_digest_unit;
  import md4_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned PHASE_WORDS    = 232;

  // rotate amounts per round, step 0 in the low five bits
  localparam logic [19:0] ROT_R1 = {5'd19, 5'd11, 5'd7, 5'd3};
  localparam logic [19:0] ROT_R2 = {5'd13, 5'd9, 5'd5, 5'd3};
  localparam logic [19:0] ROT_R3 = {5'd15, 5'd11, 5'd9, 5'd3};

  // field d in the top bits so the layout matches the output tdata
  typedef struct packed {
    logic [31:0] d;
    logic [31:0] c;
    logic [31:0] b;
    logic [31:0] a;
  } md4_digest_t;

  logic         clk_i    = 1'b0;
  logic         rst_ni   = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [39:0]  s_tdata  = '0;
  logic         s_tlast  = 1'b0;
  logic         m_tready = 1'b0;
  logic         s_tready;
  logic         m_tvalid;
  logic [127:0] m_tdata;

  // predicted chaining words, block buffer, fill level and length
  logic [31:0] ch_a, ch_b, ch_c, ch_d;
  logic [31:0] blk_buf [16];
  int unsigned blk_fill;
  logic [63:0] msg_bits;

  md4_digest_t digest_q [$];
  int unsigned err_count    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  md4_message_digest_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // digest predictor
  // ---------------------------------------------------------------------

  function automatic void md4_chain_init();
    ch_a     = INIT_A;
    ch_b     = INIT_B;
    ch_c     = INIT_C;
    ch_d     = INIT_D;
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  // 48 steps over the buffered block, then fold into the chaining words
  function automatic void md4_compress();
    logic [31:0] a, b, c, d, f, t;
    logic [3:0]  j, slot;
    logic [4:0]  s;
    int          r;
    a = ch_a;
    b = ch_b;
    c = ch_c;
    d = ch_d;
    for (r = 0; r < 48; r++) begin
      j = r[3:0];
      case (r / 16)
        0: begin
          f    = (b & c) | (~b & d);
          slot = j;
          s    = ROT_R1[5 * (r % 4) +: 5];
        end
        1: begin
          f    = ((b & c) | (b & d) | (c & d)) + K_ROUND2;
          slot = {j[1:0], j[3:2]};    // column order through the block
          s    = ROT_R2[5 * (r % 4) +: 5];
        end
        default: begin
          f    = (b ^ c ^ d) + K_ROUND3;
          slot = {j[0], j[1], j[2], j[3]};  // bit-reversed order
          s    = ROT_R3[5 * (r % 4) +: 5];
        end
      endcase
      t = a + f + blk_buf[slot];
      t = (t << s) | (t >> (6'd32 - s));
      a = d;
      d = c;
      c = b;
      b = t;
    end
    ch_a += a;
    ch_b += b;
    ch_c += c;
    ch_d += d;
  endfunction

  function automatic void md4_load_slot(input logic [31:0] w);
    blk_buf[blk_fill] = w;
    blk_fill++;
    if (blk_fill == 16) begin
      md4_compress();
      blk_fill = 0;
    end
  endfunction

  // one accepted word; on the last word pad, append the length and queue
  // the digest
  function automatic void md4_absorb(input logic [31:0] w, input logic [2:0] nb,
                                     input logic lst);
    logic [2:0]  n;
    logic [31:0] keep;
    n = (nb > FULL_WORD || !lst) ? FULL_WORD : nb;
    msg_bits = msg_bits + {58'd0, n, 3'd0};
    if (!lst) begin
      md4_load_slot(w);
      return;
    end
    if (n < FULL_WORD) begin
      case (n)
        3'd0:    keep = 32'h0000_0000;
        3'd1:    keep = 32'h0000_00ff;
        3'd2:    keep = 32'h0000_ffff;
        default: keep = 32'h00ff_ffff;
      endcase
      md4_load_slot((w & keep) | (PAD_BYTE << {n, 3'd0}));
    end else begin
      md4_load_slot(w);
      md4_load_slot(PAD_BYTE);
    end
    // no room left for the length: close this block with zeros
    if (blk_fill > 14) begin
      while (blk_fill != 0) md4_load_slot('0);
    end
    while (blk_fill < 14) md4_load_slot('0);
    md4_load_slot(msg_bits[31:0]);
    md4_load_slot(msg_bits[63:32]);
    digest_q.push_back('{d: ch_d, c: ch_c, b: ch_b, a: ch_a});
    md4_chain_init();
  endfunction

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // drive one word, honor the source idle rate, wait for the transfer
  task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tdata  = {5'd0, nb, w};
    s_tlast  = lst;
    s_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    md4_absorb(w, nb, lst);
  endtask

  // source holds off until every queued digest has been taken
  task automatic wait_for_digests();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    s_tlast  = 1'b0;
    while (digest_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_message(output int unsigned len);
    logic [31:0] w;
    int unsigned i;
    case ($urandom_range(9))
      0:       len = $urandom_range(33, 80);
      1, 2:    len = $urandom_range(12, 17);  // around the second pad block
      default: len = $urandom_range(1, 11);
    endcase
    for (i = 0; i < len; i++) begin
      case ($urandom_range(15))
        0:       w = 32'h0000_0000;
        1:       w = 32'hffff_ffff;
        default: w = $urandom;
      endcase
      send_word(w, 3'($urandom_range(7)), i == len - 1);
    end
  endtask

  task automatic run_random_messages(input int unsigned src_pct, input int unsigned sink_pct);
    int unsigned sent, n;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < PHASE_WORDS) begin
      send_random_message(n);
      sent += n;
    end
    wait_for_digests();
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  task automatic test_padding_edges();
    int unsigned i;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_word(32'hdead_beef, 3'd0, 1'b1);   // empty message, data ignored
    send_word(32'hff63_6261, 3'd3, 1'b1);   // "abc" with junk in the top byte
    send_word(32'h1234_5678, 3'd4, 1'b1);   // full last word, pad in next slot
    send_word(32'ha5a5_a5a5, 3'd7, 1'b1);   // count above four
    send_word(32'hffff_ffff, 3'd1, 1'b0);   // short word without last is full
    send_word(32'h0000_0000, 3'd6, 1'b1);
    send_word(32'h89ab_cdef, 3'd4, 1'b0);
    send_word(32'hffff_ffff, 3'd0, 1'b1);   // empty last after a full word
    // full last word in slot 13: pad lands in slot 14, length spills over
    for (i = 0; i < 14; i++) send_word($urandom, 3'd4, i == 13);
    wait_for_digests();
  endtask

  task automatic test_back_to_back();
    run_random_messages(0, 0);
  endtask

  task automatic test_source_gaps();
    run_random_messages(50, 0);
  endtask

  task automatic test_sink_backpressure();
    run_random_messages(0, 50);
  endtask

  task automatic test_both_throttled();
    run_random_messages(35, 35);
  endtask

  // ---------------------------------------------------------------------
  // output side and checking
  // ---------------------------------------------------------------------

  always @(negedge clk_i) begin
    m_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  // compare each digest transfer with the oldest prediction
  always @(posedge clk_i) begin : digest_check
    md4_digest_t want;
    int          k;
    if (rst_ni && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        err_count++;
        $display("%0t: digest expected none actual %h", $time, m_tdata);
      end else begin
        want = digest_q.pop_front();
        for (k = 0; k < 4; k++) begin
          if (m_tdata[32 * k +: 32] !== want[32 * k +: 32]) begin
            err_count++;
            $display("%0t: digest_%c expected %h actual %h", $time, 8'h61 + k,
                     want[32 * k +: 32], m_tdata[32 * k +: 32]);
          end
        end
      end
    end
  end

  // counts cycles without any transfer on either side and ends the run as a mismatch past the watchdog limit
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("md4_message_digest_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    md4_chain_init();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_padding_edges();
    test_back_to_back();
    test_source_gaps();
    test_sink_backpressure();
    test_both_throttled();

    // settle time for anything the unit might still emit
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && digest_q.size() == 0) begin
      $display("md4_message_digest_unit: match");
    end else begin
      $display("md4_message_digest_unit: mismatch");
    end
    $finish;
  end

endmodule
